### sv/gasp_pkg.sv
// gasp_pkg: shared types and codes for the grid path search block
// transaction payloads, sequencer states, cell, direction, status and register codes; no dependencies
`default_nettype none

package gasp_pkg;

  typedef struct packed {
    logic [1:0] cell_value;
    logic       last_cell;
  } in_t;

  typedef struct packed {
    logic [2:0] path_row;
    logic [2:0] path_col;
    logic       status;
    logic       last_result;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_START,
    S_H_DR,
    S_H_DC,
    S_H_ROOT,
    S_PUSH,
    S_POP_BEGIN,
    S_POP_RD,
    S_POP_CMP,
    S_POP_MOVE_RD,
    S_POP_MOVE_WR,
    S_POP_CLOSED,
    S_NB,
    S_NB_CHK,
    S_NB_NEXT,
    S_TR_WR,
    S_TR_MV,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT,
    S_NOPATH
  } state_t;

  localparam logic [1:0] CELL_WALL = 2'd1;
  localparam logic [1:0] CELL_GOAL = 2'd2;

  // direction of the move from the parent cell
  localparam logic [1:0] DIR_ROW_INC = 2'd0;
  localparam logic [1:0] DIR_ROW_DEC = 2'd1;
  localparam logic [1:0] DIR_COL_INC = 2'd2;
  localparam logic [1:0] DIR_COL_DEC = 2'd3;

  localparam logic REG_START_ROW = 1'b0;
  localparam logic REG_START_COL = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_PATH = 1'b1;

endpackage

`default_nettype wire

### sv/grid_astar_path_search_top.sv
// grid_astar_path_search_top: grid loader and A* search over four neighbors
// one sequencer sharing a single multiplier for the heuristic; uses gasp_pkg
`default_nettype none

//  channel  | direction | payload             | handshake
//  in_      | input     | gasp_pkg::in_t      | in_valid / in_stall
//  out_     | output    | gasp_pkg::out_t     | out_valid / out_stall
//  apb      | input     | start_row/start_col | psel, penable, pwrite, pready
//
// a cell is written into the grid as it is accepted; the cell flagged last_cell starts a search
// search: goal scan and closed clear over all N = rows*cols cells, then per pop a linear
// min scan over the heap, and per pushed neighbor a heuristic computed in the shared
// multiplier (HW = heuristic width) before the heap write; skipped ones are not pushed
// trace back pushes each path cell on a stack; each result then waits out any stall
// input is stalled until the last result leaves; rst_n is synchronous, memories hold no reset

module grid_astar_path_search_top #(
  parameter int GRID_ROWS  = 8,
  parameter int GRID_COLS  = 8,
  parameter int HEAP_DEPTH = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire gasp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output gasp_pkg::out_t      out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import gasp_pkg::*;

  localparam int N    = GRID_ROWS * GRID_COLS;
  localparam int RW   = $clog2(GRID_ROWS);
  localparam int CW   = $clog2(GRID_COLS);
  localparam int IW   = $clog2(N);
  localparam int DW   = (RW > CW) ? RW : CW;
  localparam int HW   = DW + 1;
  localparam int SW   = 2 * DW + 1;
  localparam int BW   = $clog2(HW);
  localparam int GW   = $clog2(N + 1);
  localparam int FW   = ((GW > HW) ? GW : HW) + 1;
  localparam int OW   = $clog2(4 * N + 2);
  localparam int CNTW = $clog2(HEAP_DEPTH + 1);
  localparam int HAW  = $clog2(HEAP_DEPTH);
  localparam int PW   = $clog2(N + 1);

  typedef struct packed {
    logic [FW-1:0] f;
    logic [OW-1:0] ord;
    logic [GW-1:0] g;
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic [1:0]    dir;
  } hent_t;

  function automatic logic [IW-1:0] idx_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return IW'(IW'(r) * IW'(GRID_COLS)) + IW'(c);
  endfunction

  // control registers
  state_t           state_r, state_nxt;
  logic [IW-1:0]    load_pos_r, load_pos_nxt;
  logic [2:0]       start_row_r, start_col_r;
  logic             goal_vld_r, goal_vld_nxt;
  logic [CNTW-1:0]  heap_cnt_r, heap_cnt_nxt;
  logic [OW-1:0]    ord_r, ord_nxt;
  logic             out_vld_r, out_vld_nxt;

  // datapath registers
  logic [RW-1:0]    goal_row_r, goal_row_nxt;
  logic [CW-1:0]    goal_col_r, goal_col_nxt;
  logic [IW-1:0]    scan_idx_r, scan_idx_nxt;
  logic [RW-1:0]    scan_row_r, scan_row_nxt;
  logic [CW-1:0]    scan_col_r, scan_col_nxt;
  hent_t            cand_r, cand_nxt;
  logic             from_start_r, from_start_nxt;
  logic [2*DW-1:0]  sq_r, sq_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [HW-1:0]    root_r, root_nxt;
  logic [BW-1:0]    bit_r, bit_nxt;
  hent_t            best_r, best_nxt;
  logic [HAW-1:0]   best_idx_r, best_idx_nxt;
  logic [HAW-1:0]   pop_i_r, pop_i_nxt;
  logic [1:0]       nb_dir_r, nb_dir_nxt;
  logic [RW-1:0]    nb_row_r, nb_row_nxt;
  logic [CW-1:0]    nb_col_r, nb_col_nxt;
  logic [RW-1:0]    tr_row_r, tr_row_nxt;
  logic [CW-1:0]    tr_col_r, tr_col_nxt;
  logic [PW-1:0]    path_n_r, path_n_nxt;
  logic [IW-1:0]    out_pos_r, out_pos_nxt;
  out_t             out_data_r, out_data_nxt;

  // memories and their ports
  logic [1:0]        grid_mem [N];
  logic              closed_mem [N];
  logic [1:0]        parent_mem [N];
  hent_t             heap_mem [HEAP_DEPTH];
  logic [RW+CW-1:0]  stack_mem [N];

  logic              grid_we, closed_we, closed_wd, parent_we, heap_we, stack_we;
  logic [IW-1:0]     grid_waddr, grid_raddr, closed_waddr, closed_raddr;
  logic [IW-1:0]     parent_addr, stack_waddr, stack_raddr;
  logic [HAW-1:0]    heap_waddr, heap_raddr;
  logic [1:0]        grid_wd, grid_rdata_r, parent_rdata_r;
  logic              closed_rdata_r;
  hent_t             heap_wd, heap_rdata_r;
  logic [RW+CW-1:0]  stack_wd, stack_rdata_r;

  // shared multiplier
  logic [HW-1:0]     mul_a, mul_b;
  logic [2*HW-1:0]   prod;
  assign prod = mul_a * mul_b;

  logic in_acc, out_acc, cfg_wr, start_ok, is_better;
  logic [DW-1:0] dr, dc;
  logic [HW-1:0] root_try;
  logic [RW-1:0] start_row_g;
  logic [CW-1:0] start_col_g;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_vld_r && !out_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_START_COL) ? 32'(start_col_r) : 32'(start_row_r);

  assign start_ok    = (32'(start_row_r) < GRID_ROWS) && (32'(start_col_r) < GRID_COLS);
  assign start_row_g = RW'(start_row_r);
  assign start_col_g = CW'(start_col_r);
  assign dr = DW'((cand_r.row > goal_row_r) ? cand_r.row - goal_row_r
                                            : goal_row_r - cand_r.row);
  assign dc = DW'((cand_r.col > goal_col_r) ? cand_r.col - goal_col_r
                                            : goal_col_r - cand_r.col);
  assign root_try  = root_r | (HW'(1) << bit_r);
  assign is_better = (heap_rdata_r.f < best_r.f) ||
                     ((heap_rdata_r.f == best_r.f) && (heap_rdata_r.ord < best_r.ord));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:        if (in_acc && in_data.last_cell) state_nxt = S_SCAN_RD;
      S_SCAN_RD:     state_nxt = S_SCAN_CHK;
      S_SCAN_CHK:    state_nxt = (scan_idx_r == IW'(N - 1)) ? S_START : S_SCAN_RD;
      S_START:       state_nxt = (goal_vld_r && start_ok) ? S_H_DR : S_NOPATH;
      S_H_DR:        state_nxt = S_H_DC;
      S_H_DC:        state_nxt = S_H_ROOT;
      S_H_ROOT:      if (bit_r == '0) state_nxt = S_PUSH;
      S_PUSH:        state_nxt = from_start_r ? S_POP_BEGIN : S_NB_NEXT;
      S_POP_BEGIN:   state_nxt = (heap_cnt_r == '0) ? S_NOPATH : S_POP_RD;
      S_POP_RD:      state_nxt = S_POP_CMP;
      S_POP_CMP:     state_nxt = (CNTW'(pop_i_r) == heap_cnt_r - CNTW'(1)) ? S_POP_MOVE_RD
                                                                          : S_POP_RD;
      S_POP_MOVE_RD: state_nxt = S_POP_MOVE_WR;
      S_POP_MOVE_WR: state_nxt = S_POP_CLOSED;
      S_POP_CLOSED: begin
        if (closed_rdata_r) state_nxt = S_POP_BEGIN;
        else if (best_r.row == goal_row_r && best_r.col == goal_col_r) state_nxt = S_TR_WR;
        else state_nxt = S_NB;
      end
      S_NB: begin
        unique case (nb_dir_r)
          DIR_ROW_INC: state_nxt = (best_r.row != RW'(GRID_ROWS - 1)) ? S_NB_CHK : S_NB_NEXT;
          DIR_ROW_DEC: state_nxt = (best_r.row != '0) ? S_NB_CHK : S_NB_NEXT;
          DIR_COL_INC: state_nxt = (best_r.col != CW'(GRID_COLS - 1)) ? S_NB_CHK : S_NB_NEXT;
          default:     state_nxt = (best_r.col != '0) ? S_NB_CHK : S_NB_NEXT;
        endcase
      end
      S_NB_CHK:      state_nxt = (grid_rdata_r != CELL_WALL && !closed_rdata_r) ? S_H_DR
                                                                                : S_NB_NEXT;
      S_NB_NEXT:     state_nxt = (nb_dir_r == DIR_COL_DEC) ? S_POP_BEGIN : S_NB;
      S_TR_WR:       state_nxt = (tr_row_r == start_row_g && tr_col_r == start_col_g)
                                 ? S_OUT_RD : S_TR_MV;
      S_TR_MV:       state_nxt = S_TR_WR;
      S_OUT_RD:      state_nxt = S_OUT_LD;
      S_OUT_LD:      state_nxt = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (out_acc) state_nxt = out_data_r.last_result ? S_IDLE : S_OUT_RD;
      end
      S_NOPATH:      state_nxt = S_OUT_WAIT;
      default:       state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory controls and outputs
  always_comb begin
    load_pos_nxt   = load_pos_r;
    goal_vld_nxt   = goal_vld_r;
    heap_cnt_nxt   = heap_cnt_r;
    ord_nxt        = ord_r;
    out_vld_nxt    = out_vld_r;
    goal_row_nxt   = goal_row_r;
    goal_col_nxt   = goal_col_r;
    scan_idx_nxt   = scan_idx_r;
    scan_row_nxt   = scan_row_r;
    scan_col_nxt   = scan_col_r;
    cand_nxt       = cand_r;
    from_start_nxt = from_start_r;
    sq_nxt         = sq_r;
    sum_nxt        = sum_r;
    root_nxt       = root_r;
    bit_nxt        = bit_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    pop_i_nxt      = pop_i_r;
    nb_dir_nxt     = nb_dir_r;
    nb_row_nxt     = nb_row_r;
    nb_col_nxt     = nb_col_r;
    tr_row_nxt     = tr_row_r;
    tr_col_nxt     = tr_col_r;
    path_n_nxt     = path_n_r;
    out_pos_nxt    = out_pos_r;
    out_data_nxt   = out_data_r;

    grid_we      = 1'b0;
    grid_waddr   = load_pos_r;
    grid_wd      = in_data.cell_value;
    grid_raddr   = scan_idx_r;
    closed_we    = 1'b0;
    closed_waddr = scan_idx_r;
    closed_wd    = 1'b0;
    closed_raddr = idx_of(best_r.row, best_r.col);
    parent_we    = 1'b0;
    parent_addr  = idx_of(tr_row_r, tr_col_r);
    heap_we      = 1'b0;
    heap_waddr   = heap_cnt_r[HAW-1:0];
    heap_wd      = cand_r;
    heap_raddr   = pop_i_r;
    stack_we     = 1'b0;
    stack_waddr  = path_n_r[IW-1:0];
    stack_wd     = {tr_row_r, tr_col_r};
    stack_raddr  = out_pos_r;
    mul_a        = HW'(dr);
    mul_b        = HW'(dr);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          grid_we      = 1'b1;
          load_pos_nxt = (load_pos_r == IW'(N - 1)) ? '0 : load_pos_r + IW'(1);
          if (in_data.last_cell) begin
            load_pos_nxt = '0;
            goal_vld_nxt = 1'b0;
            goal_row_nxt = '0;
            goal_col_nxt = '0;
            scan_idx_nxt = '0;
            scan_row_nxt = '0;
            scan_col_nxt = '0;
          end
        end
      end
      S_SCAN_RD: begin
        closed_we = 1'b1;
      end
      S_SCAN_CHK: begin
        if (grid_rdata_r == CELL_GOAL) begin
          goal_vld_nxt = 1'b1;
          goal_row_nxt = scan_row_r;
          goal_col_nxt = scan_col_r;
        end
        scan_idx_nxt = scan_idx_r + IW'(1);
        if (scan_col_r == CW'(GRID_COLS - 1)) begin
          scan_col_nxt = '0;
          scan_row_nxt = scan_row_r + RW'(1);
        end else begin
          scan_col_nxt = scan_col_r + CW'(1);
        end
      end
      S_START: begin
        heap_cnt_nxt   = '0;
        ord_nxt        = '0;
        from_start_nxt = 1'b1;
        cand_nxt.row   = start_row_g;
        cand_nxt.col   = start_col_g;
        cand_nxt.g     = '0;
        cand_nxt.dir   = DIR_ROW_INC;
      end
      S_H_DR: begin
        sq_nxt   = prod[2*DW-1:0];
        root_nxt = '0;
        bit_nxt  = BW'(HW - 1);
      end
      S_H_DC: begin
        mul_a   = HW'(dc);
        mul_b   = HW'(dc);
        sum_nxt = SW'(sq_r) + SW'(prod[2*DW-1:0]);
      end
      S_H_ROOT: begin
        mul_a = root_try;
        mul_b = root_try;
        if (prod <= (2*HW)'(sum_r)) root_nxt = root_try;
        bit_nxt = bit_r - BW'(1);
      end
      S_PUSH: begin
        heap_wd.f   = FW'(cand_r.g) + FW'(root_r);
        heap_wd.ord = ord_r;
        if (heap_cnt_r < CNTW'(HEAP_DEPTH)) begin
          heap_we      = 1'b1;
          heap_cnt_nxt = heap_cnt_r + CNTW'(1);
          ord_nxt      = ord_r + OW'(1);
        end
      end
      S_POP_BEGIN: begin
        pop_i_nxt = '0;
      end
      S_POP_RD: begin
      end
      S_POP_CMP: begin
        if (pop_i_r == '0 || is_better) begin
          best_nxt     = heap_rdata_r;
          best_idx_nxt = pop_i_r;
        end
        pop_i_nxt = pop_i_r + HAW'(1);
      end
      S_POP_MOVE_RD: begin
        heap_raddr = HAW'(heap_cnt_r - CNTW'(1));
      end
      S_POP_MOVE_WR: begin
        heap_we      = 1'b1;
        heap_waddr   = best_idx_r;
        heap_wd      = heap_rdata_r;
        heap_cnt_nxt = heap_cnt_r - CNTW'(1);
      end
      S_POP_CLOSED: begin
        if (!closed_rdata_r) begin
          closed_we    = 1'b1;
          closed_waddr = idx_of(best_r.row, best_r.col);
          closed_wd    = 1'b1;
          parent_we    = 1'b1;
          parent_addr  = idx_of(best_r.row, best_r.col);
        end
        nb_dir_nxt = DIR_ROW_INC;
        tr_row_nxt = best_r.row;
        tr_col_nxt = best_r.col;
        path_n_nxt = '0;
      end
      S_NB: begin
        nb_row_nxt = best_r.row;
        nb_col_nxt = best_r.col;
        unique case (nb_dir_r)
          DIR_ROW_INC: nb_row_nxt = best_r.row + RW'(1);
          DIR_ROW_DEC: nb_row_nxt = best_r.row - RW'(1);
          DIR_COL_INC: nb_col_nxt = best_r.col + CW'(1);
          default:     nb_col_nxt = best_r.col - CW'(1);
        endcase
        grid_raddr   = idx_of(nb_row_nxt, nb_col_nxt);
        closed_raddr = idx_of(nb_row_nxt, nb_col_nxt);
      end
      S_NB_CHK: begin
        from_start_nxt = 1'b0;
        cand_nxt.row   = nb_row_r;
        cand_nxt.col   = nb_col_r;
        cand_nxt.g     = best_r.g + GW'(1);
        cand_nxt.dir   = nb_dir_r;
      end
      S_NB_NEXT: begin
        nb_dir_nxt = nb_dir_r + 2'd1;
      end
      S_TR_WR: begin
        stack_we    = 1'b1;
        path_n_nxt  = path_n_r + PW'(1);
        out_pos_nxt = path_n_r[IW-1:0];
      end
      S_TR_MV: begin
        // step back against the move that reached this cell
        unique case (parent_rdata_r)
          DIR_ROW_INC: tr_row_nxt = tr_row_r - RW'(1);
          DIR_ROW_DEC: tr_row_nxt = tr_row_r + RW'(1);
          DIR_COL_INC: tr_col_nxt = tr_col_r - CW'(1);
          default:     tr_col_nxt = tr_col_r + CW'(1);
        endcase
      end
      S_OUT_RD: begin
      end
      S_OUT_LD: begin
        out_vld_nxt              = 1'b1;
        out_data_nxt.path_row    = 3'(stack_rdata_r[RW+CW-1:CW]);
        out_data_nxt.path_col    = 3'(stack_rdata_r[CW-1:0]);
        out_data_nxt.status      = STATUS_OK;
        out_data_nxt.last_result = (out_pos_r == '0);
      end
      S_OUT_WAIT: begin
        if (out_acc) begin
          out_vld_nxt = 1'b0;
          out_pos_nxt = out_pos_r - IW'(1);
        end
      end
      S_NOPATH: begin
        out_vld_nxt              = 1'b1;
        out_data_nxt.path_row    = '0;
        out_data_nxt.path_col    = '0;
        out_data_nxt.status      = STATUS_NO_PATH;
        out_data_nxt.last_result = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_pos_r  <= '0;
      start_row_r <= '0;
      start_col_r <= '0;
      goal_vld_r  <= 1'b0;
      heap_cnt_r  <= '0;
      ord_r       <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_pos_r <= load_pos_nxt;
      goal_vld_r <= goal_vld_nxt;
      heap_cnt_r <= heap_cnt_nxt;
      ord_r      <= ord_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_START_COL) start_col_r <= pwdata[2:0];
        else start_row_r <= pwdata[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    goal_row_r   <= goal_row_nxt;
    goal_col_r   <= goal_col_nxt;
    scan_idx_r   <= scan_idx_nxt;
    scan_row_r   <= scan_row_nxt;
    scan_col_r   <= scan_col_nxt;
    cand_r       <= cand_nxt;
    from_start_r <= from_start_nxt;
    sq_r         <= sq_nxt;
    sum_r        <= sum_nxt;
    root_r       <= root_nxt;
    bit_r        <= bit_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    pop_i_r      <= pop_i_nxt;
    nb_dir_r     <= nb_dir_nxt;
    nb_row_r     <= nb_row_nxt;
    nb_col_r     <= nb_col_nxt;
    tr_row_r     <= tr_row_nxt;
    tr_col_r     <= tr_col_nxt;
    path_n_r     <= path_n_nxt;
    out_pos_r    <= out_pos_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wd;
    grid_rdata_r <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (closed_we) closed_mem[closed_waddr] <= closed_wd;
    closed_rdata_r <= closed_mem[closed_raddr];
  end

  always_ff @(posedge clk) begin
    if (parent_we) parent_mem[parent_addr] <= best_r.dir;
    parent_rdata_r <= parent_mem[parent_addr];
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wd;
    heap_rdata_r <= heap_mem[heap_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wd;
    stack_rdata_r <= stack_mem[stack_raddr];
  end

endmodule

`default_nettype wire

### verif/tb_grid_astar_path_search_top.sv
// tb_grid_astar_path_search_top: self-checking bench for the grid A* path search block
// loads grids cell by cell, predicts each search's path in a local model; uses gasp_pkg
`default_nettype none

module tb_grid_astar_path_search_top;
  import gasp_pkg::*;

  localparam int ROWS = 8;
  localparam int COLS = 8;
  localparam int NCELL = ROWS * COLS;
  localparam int HEAP_MAX = 256;
  localparam longint CYCLE_LIMIT = 10000000;
  localparam logic [1:0] CELL_OPEN = 2'd0;
  localparam logic [1:0] CELL_ODD = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  grid_astar_path_search_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [1:0] grid_mem [NCELL];
  int unsigned load_idx;
  logic [2:0] row0, col0;

  in_t cell_queue[$];
  out_t path_queue[$];
  int errors = 0;
  int searches = 0;
  int path_cells = 0;
  int no_path_count = 0;
  longint cycles = 0;

  typedef struct {
    int f;
    int ord;
    int g;
    int idx;
    logic [1:0] dir;
  } open_rec_t;

  function automatic int dist_floor_sqrt(int pos, int goal);
    int dr, dc, v, r;
    dr = pos / COLS - goal / COLS;
    dc = pos % COLS - goal % COLS;
    v = dr * dr + dc * dc;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  task automatic predict_path();
    logic closed [NCELL];
    logic [1:0] came_from [NCELL];
    open_rec_t open_list[$];
    open_rec_t e;
    open_rec_t add;
    int goal, start, seq, best, cur, nb, r, c, n;
    bit have_goal, found;
    int trail[$];
    out_t o;
    goal = 0;
    start = 0;
    have_goal = 0;
    found = 0;
    seq = 0;
    for (int i = 0; i < NCELL; i++) begin
      closed[i] = 1'b0;
      came_from[i] = DIR_ROW_INC;
      if (grid_mem[i] == CELL_GOAL) begin
        goal = i;
        have_goal = 1;
      end
    end
    searches++;
    if (have_goal) begin
      start = row0 * COLS + col0;
      add.f = dist_floor_sqrt(start, goal);
      add.ord = seq;
      add.g = 0;
      add.idx = start;
      add.dir = DIR_ROW_INC;
      open_list.insert(open_list.size(), add);
      seq++;
      while (open_list.size() > 0 && !found) begin
        best = 0;
        for (int i = 1; i < open_list.size(); i++)
          if (open_list[i].f < open_list[best].f ||
              (open_list[i].f == open_list[best].f && open_list[i].ord < open_list[best].ord))
            best = i;
        e = open_list[best];
        open_list.delete(best);
        cur = e.idx;
        if (closed[cur]) continue;
        closed[cur] = 1'b1;
        came_from[cur] = e.dir;
        if (cur == goal) begin
          found = 1;
        end else begin
          r = cur / COLS;
          c = cur % COLS;
          for (int d = 0; d < 4; d++) begin
            nb = -1;
            case (d)
              0: if (r + 1 < ROWS) nb = cur + COLS;
              1: if (r > 0) nb = cur - COLS;
              2: if (c + 1 < COLS) nb = cur + 1;
              default: if (c > 0) nb = cur - 1;
            endcase
            if (nb >= 0 && grid_mem[nb] != CELL_WALL && !closed[nb] &&
                open_list.size() < HEAP_MAX) begin
              add.f = e.g + 1 + dist_floor_sqrt(nb, goal);
              add.ord = seq;
              add.g = e.g + 1;
              add.idx = nb;
              add.dir = 2'(d);
              open_list.insert(open_list.size(), add);
              seq++;
            end
          end
        end
      end
    end
    if (!found) begin
      o.path_row = '0;
      o.path_col = '0;
      o.status = STATUS_NO_PATH;
      o.last_result = 1'b1;
      path_queue.insert(path_queue.size(), o);
      no_path_count++;
      return;
    end
    cur = goal;
    trail.push_front(cur);
    n = 1;
    while (cur != start && n < NCELL) begin
      case (came_from[cur])
        DIR_ROW_INC: cur = (cur >= COLS) ? cur - COLS : cur;
        DIR_ROW_DEC: cur = (cur + COLS < NCELL) ? cur + COLS : cur;
        DIR_COL_INC: cur = (cur > 0) ? cur - 1 : cur;
        default: cur = (cur + 1 < NCELL) ? cur + 1 : cur;
      endcase
      trail.push_front(cur);
      n++;
    end
    foreach (trail[i]) begin
      o.path_row = 3'(trail[i] / COLS);
      o.path_col = 3'(trail[i] % COLS);
      o.status = STATUS_OK;
      o.last_result = (i == trail.size() - 1);
      path_queue.insert(path_queue.size(), o);
    end
  endtask

  // model one accepted cell
  task automatic accept_cell(in_t t);
    grid_mem[load_idx] = t.cell_value;
    load_idx = (load_idx + 1) % NCELL;
    if (t.last_cell) begin
      load_idx = 0;
      predict_path();
    end
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        accept_cell(in_data);
        send_gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cell_queue.size() > 0) begin
          in_data <= cell_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  int recv_wait = 0;
  int hold_off = 0;
  bit hold_armed = 1'b0;
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (path_queue.size() == 0) begin
          $error("unexpected result row=%0d col=%0d", out_data.path_row, out_data.path_col);
          errors++;
        end else begin
          out_t x;
          x = path_queue.pop_front();
          path_cells++;
          if (x.path_row !== out_data.path_row) begin
            $error("path_row expected %0d got %0d", x.path_row, out_data.path_row); errors++;
          end
          if (x.path_col !== out_data.path_col) begin
            $error("path_col expected %0d got %0d", x.path_col, out_data.path_col); errors++;
          end
          if (x.status !== out_data.status) begin
            $error("status expected %0d got %0d", x.status, out_data.status); errors++;
          end
          if (x.last_result !== out_data.last_result) begin
            $error("last_result expected %0d got %0d", x.last_result, out_data.last_result);
            errors++;
          end
        end
        recv_wait = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) recv_wait = 0;
      end
      // long hold starts once the sender waits behind a busy block
      if (hold_armed && in_valid && in_stall) begin
        hold_armed = 1'b0;
        hold_off = 400;
      end
      if (hold_off > 0) begin
        if (out_valid) hold_off--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** grid_astar_path_search_top: FAILED **");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd4 * REG_START_ROW) row0 = val[2:0];
    else col0 = val[2:0];
  endtask

  task automatic set_start(logic [2:0] r, logic [2:0] c);
    apb_write(3'd4 * REG_START_ROW, {29'd0, r});
    apb_write(3'd4 * REG_START_COL, {29'd0, c});
  endtask

  // queue a full grid; walls placed with probability wall_pct
  task automatic queue_grid(int wall_pct, int goal_cell, bit odd_vals);
    in_t t;
    for (int i = 0; i < NCELL; i++) begin
      t.cell_value = ($urandom_range(0, 99) < wall_pct) ? CELL_WALL : CELL_OPEN;
      if (odd_vals && $urandom_range(0, 7) == 0) t.cell_value = CELL_ODD;
      if (i == goal_cell) t.cell_value = CELL_GOAL;
      t.last_cell = (i == NCELL - 1);
      cell_queue.insert(cell_queue.size(), t);
    end
  endtask

  task automatic queue_cell(logic [1:0] v, logic l);
    in_t t;
    t.cell_value = v;
    t.last_cell = l;
    cell_queue.insert(cell_queue.size(), t);
  endtask

  task automatic drain();
    wait (cell_queue.size() == 0 && !in_valid);
    wait (path_queue.size() == 0);
    repeat (3000) @(posedge clk);
  endtask

  initial begin
    int len;
    for (int i = 0; i < NCELL; i++) grid_mem[i] = CELL_OPEN;
    load_idx = 0;
    row0 = 0;
    col0 = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full grid with light walls and odd values, the only goal in the first cell
    set_start(3'd7, 3'd7);
    queue_grid(15, 0, 1);
    drain();
    // early last cell clears the goal: no goal anywhere
    queue_cell(CELL_OPEN, 1'b1);
    drain();
    // start equals goal
    set_start(3'd0, 3'd0);
    queue_cell(CELL_GOAL, 1'b1);
    drain();
    // start on a wall, goal two cells along the top row
    queue_cell(CELL_WALL, 1'b0);
    queue_cell(CELL_OPEN, 1'b0);
    queue_cell(CELL_GOAL, 1'b1);
    drain();
    // goal in the corner walled in, unreachable
    set_start(3'd5, 3'd6);
    for (int i = 0; i < 9; i++)
      queue_cell((i == 0) ? CELL_GOAL : (i == 1 || i == 8) ? CELL_WALL : CELL_OPEN, i == 8);
    drain();

    // receiver holds off while a second load waits behind the first search
    set_start(3'd3, 3'd2);
    hold_armed = 1'b1;
    for (int j = 0; j < 10; j++) queue_cell((j == 9) ? CELL_GOAL : CELL_OPEN, j == 9);
    for (int j = 0; j < 10; j++) queue_cell(2'($urandom_range(0, 3)), j == 9);
    drain();

    // short random loads with random starts
    for (int k = 0; k < 4; k++) begin
      set_start(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      len = $urandom_range(3, 8);
      for (int j = 0; j < len; j++) queue_cell(2'($urandom_range(0, 3)), j == len - 1);
      drain();
    end

    $display("searches run: %0d, path results checked: %0d, no-path results: %0d",
             searches, path_cells, no_path_count);
    if (errors == 0) $display("** grid_astar_path_search_top: PASSED **");
    else $display("** grid_astar_path_search_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
